@@ design/fqrv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fqrv_pkg: shared types and constants for the tag queue
// Operation and status codes, FSM states and the control word broadcast
// to every queue cell.
// ----------------------------------------------------------------------------
package fqrv_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int VALUE_BITS_DEF = 32;
  localparam int VALUE_W        = 32;
  localparam int EXT_W          = 64;

  typedef enum logic [1:0] {
    OP_PUSH     = 2'd0,
    OP_POP      = 2'd1,
    OP_REMOVE   = 2'd2,
    OP_CONTAINS = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_MISS  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY,
    S_RESP
  } state_t;

  typedef struct packed {
    logic cmp;
    logic push;
    logic pop;
    logic rem_go;
  } cell_ctl_t;

endpackage
`default_nettype wire

@@ design/fqrv_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fqrv_cell: one queue slot
// Holds one tag and its valid bit, compares against the broadcast key,
// loads on push at the tail and takes its newer neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module fqrv_cell #(
  parameter int VALUE_BITS = fqrv_pkg::VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire fqrv_pkg::cell_ctl_t   ctl,
  input  wire logic [VALUE_BITS-1:0] key,
  input  wire logic                  prev_vld,
  input  wire logic [VALUE_BITS-1:0] next_val,
  input  wire logic                  next_vld,
  input  wire logic                  above_in,
  output logic      [VALUE_BITS-1:0] val,
  output logic                       vld,
  output logic                       above_out
);
  import fqrv_pkg::*;

  logic hit;
  logic load;
  logic shift;

  assign load      = ctl.push && !vld && prev_vld;
  assign shift     = ctl.pop || (ctl.rem_go && !above_in);
  assign above_out = hit | above_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
      hit <= 1'b0;
    end else begin
      if (ctl.cmp) begin
        hit <= vld && (val == key);
      end
      if (load) begin
        vld <= 1'b1;
      end else if (shift) begin
        vld <= next_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      val <= key;
    end else if (shift) begin
      val <= next_val;
    end
  end

endmodule
`default_nettype wire

@@ design/fifo_queue_with_remove_by_value.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_queue_with_remove_by_value: bounded tag queue with remove and search
// Operations arrive on the s_ side: s_tuser carries the operation (push, pop,
// remove by value, contains), s_tdata the tag. One result per operation
// leaves on the m_ side: m_tuser carries the status (done, full, empty,
// not found), m_tdata the popped tag, the found flag and the entry count.
// Storage is a row of DEPTH cells, oldest entry in cell 0. Every cell
// compares its tag with the key at once; the newest-match search ripples
// across the row, and a pop or remove shifts entries one cell down.
// The input transaction is latched, the cells compare (S_CMP), the queue
// updates (S_APPLY) and the result is presented (S_RESP). One operation is
// in flight at a time; s_tready stays low until the result transaction
// completes. A stalled receiver holds the result and the input side. Reset
// empties the queue at once (valid bits clear) and returns to idle; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module fifo_queue_with_remove_by_value #(
  parameter  int DEPTH      = fqrv_pkg::DEPTH_DEF,
  parameter  int VALUE_BITS = fqrv_pkg::VALUE_BITS_DEF,
  localparam int CNT_W      = $clog2(DEPTH + 1),
  localparam int M_TDATA_W  = ((fqrv_pkg::VALUE_W + 1 + CNT_W + 7) / 8) * 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [fqrv_pkg::VALUE_W-1:0]  s_tdata,   // value
  input  wire logic [1:0]                    s_tuser,   // op
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [M_TDATA_W-1:0]          m_tdata,   // out_value, found, count
  output logic      [1:0]                    m_tuser    // status
);
  import fqrv_pkg::*;

  state_t                  state;
  state_t                  state_next;
  op_t                     op_r;
  logic [VALUE_BITS-1:0]   key;
  status_t                 status_r;
  status_t                 status_next;
  logic [VALUE_W-1:0]      out_value_r;
  logic [VALUE_W-1:0]      out_value_next;
  logic                    found_r;
  logic                    found_next;
  logic [CNT_W-1:0]        held;
  logic [CNT_W-1:0]        held_next;
  cell_ctl_t               ctl;
  logic                    do_push;
  logic                    do_pop;
  logic                    do_rem;
  logic [EXT_W-1:0]        in_ext;
  logic [EXT_W-1:0]        head_ext;

  logic [VALUE_BITS-1:0]   val   [DEPTH];
  logic                    vld   [DEPTH];
  logic                    above [DEPTH+1];

  logic full;
  logic empty;
  logic any_hit;

  assign full    = (held == CNT_W'(DEPTH));
  assign empty   = (held == '0);
  assign any_hit = above[0];
  assign in_ext  = EXT_W'(s_tdata);

  always_comb begin
    head_ext                   = '0;
    head_ext[VALUE_BITS-1:0]   = val[0];
  end

  assign above[DEPTH] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_BITS-1:0] nval;
    logic                  nvld;
    logic                  pvld;
    if (i == DEPTH - 1) begin : g_last
      assign nval = '0;
      assign nvld = 1'b0;
    end else begin : g_mid
      assign nval = val[i+1];
      assign nvld = vld[i+1];
    end
    if (i == 0) begin : g_first
      assign pvld = 1'b1;
    end else begin : g_rest
      assign pvld = vld[i-1];
    end
    fqrv_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .key      (key),
      .prev_vld (pvld),
      .next_val (nval),
      .next_vld (nvld),
      .above_in (above[i+1]),
      .val      (val[i]),
      .vld      (vld[i]),
      .above_out(above[i])
    );
  end

  // decode the operation against the registered compare results
  always_comb begin
    status_next    = STAT_DONE;
    out_value_next = '0;
    found_next     = 1'b0;
    do_push        = 1'b0;
    do_pop         = 1'b0;
    do_rem         = 1'b0;
    case (op_r)
      OP_PUSH: begin
        if (full) begin
          status_next = STAT_FULL;
        end else begin
          do_push = 1'b1;
        end
      end
      OP_POP: begin
        if (empty) begin
          status_next = STAT_EMPTY;
        end else begin
          do_pop         = 1'b1;
          out_value_next = head_ext[VALUE_W-1:0];
        end
      end
      OP_REMOVE: begin
        if (key != '0) begin
          if (any_hit) begin
            found_next = 1'b1;
            do_rem     = 1'b1;
          end else begin
            status_next = STAT_MISS;
          end
        end
      end
      OP_CONTAINS: begin
        if (any_hit) begin
          found_next = 1'b1;
        end else begin
          status_next = STAT_MISS;
        end
      end
      default: begin
        status_next = STAT_DONE;
      end
    endcase
  end

  always_comb begin
    held_next = held;
    if (do_push) begin
      held_next = held + CNT_W'(1);
    end else if (do_pop || do_rem) begin
      held_next = held - CNT_W'(1);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
      end
      S_CMP: begin
        ctl.cmp = 1'b1;
      end
      S_APPLY: begin
        ctl.push   = do_push;
        ctl.pop    = do_pop;
        ctl.rem_go = do_rem;
      end
      S_RESP: begin
        m_tvalid = 1'b1;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      held  <= '0;
    end else begin
      state <= state_next;
      if (state == S_APPLY) begin
        held <= held_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_r <= op_t'(s_tuser);
      key  <= in_ext[VALUE_BITS-1:0];
    end
    if (state == S_APPLY) begin
      status_r    <= status_next;
      out_value_r <= out_value_next;
      found_r     <= found_next;
    end
  end

  assign m_tuser = status_r;
  assign m_tdata = M_TDATA_W'({held, found_r, out_value_r});

endmodule
`default_nettype wire

@@ design/fqrv_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fqrv_checker: port-level checks for the tag queue
// Watches the stream ports of the top level; attached by bind.
// ----------------------------------------------------------------------------
module fqrv_checker #(
  parameter  int DEPTH     = fqrv_pkg::DEPTH_DEF,
  localparam int CNT_W     = $clog2(DEPTH + 1),
  localparam int M_TDATA_W = ((fqrv_pkg::VALUE_W + 1 + CNT_W + 7) / 8) * 8
) (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_tvalid,
  input wire logic                         s_tready,
  input wire logic                         m_tvalid,
  input wire logic                         m_tready,
  input wire logic [M_TDATA_W-1:0]         m_tdata,
  input wire logic [1:0]                   m_tuser
);
  import fqrv_pkg::*;

  localparam int CNT_LO = VALUE_W + 1;

  // one transaction in flight: no new input right after one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an operation is in flight");

  // result is presented after the compare and update states that follow the input transaction
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> ##2 m_tvalid)
    else $error("result not presented on time");

  // input side stays closed while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input open while a result is pending");

  // held result stays put under backpressure
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result changed while stalled");

  // count never exceeds the queue depth
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[CNT_LO +: CNT_W] <= CNT_W'(DEPTH)))
    else $error("count above depth");

endmodule

bind fifo_queue_with_remove_by_value fqrv_checker #(
  .DEPTH(DEPTH)
) u_fqrv_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the bounded tag queue
// Drives push, pop, remove-by-value and contains transactions: a short
// directed table first, then random traffic that alternates between
// filling and draining phases. Each accepted operation runs through an
// in-bench queue predictor. Each result transaction is checked field by
// field against the oldest expected result, the table's own for typed rows.
// Both sides idle at random; the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import fqrv_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int RANDOM_OPS  = 2000;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AT     = 500;
  localparam int HOLD_CYCLES = 200;
  localparam int CALM_FROM   = 900;
  localparam int CALM_TO     = 1200;
  localparam int PLAN_ROWS   = 22;

  typedef struct packed {
    status_t     status;
    logic [31:0] out_value;
    logic        found;
    logic [4:0]  count;
  } queue_result_t;

  typedef struct packed {
    op_t           op;
    logic [31:0]   value;
    logic [7:0]    reps;
    logic          typed;
    queue_result_t res;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;

  logic          cur_typed;
  queue_result_t cur_res;
  logic [31:0]   model_tags[$];
  queue_result_t pending_results[$];
  logic [31:0]   tag_pool[8];
  plan_row_t     plan_table[PLAN_ROWS];
  int            mismatch_count = 0;
  int            cycle_count = 0;
  int            op_index;
  bit            calm;

  fifo_queue_with_remove_by_value i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // value
    .s_tuser  (s_tuser),   // op
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // out_value, found, count
    .m_tuser  (m_tuser)    // status
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic queue_result_t queue_apply(op_t op, logic [31:0] value);
    queue_result_t r;
    int            hit;
    r   = '{STAT_DONE, 32'h0, 1'b0, 5'd0};
    hit = -1;
    if (op == OP_REMOVE || op == OP_CONTAINS) begin
      for (int i = model_tags.size() - 1; i >= 0 && hit < 0; i--) begin
        if (model_tags[i] == value) hit = i;
      end
    end
    case (op)
      OP_PUSH: begin
        if (model_tags.size() >= QUEUE_DEPTH) r.status = STAT_FULL;
        else model_tags.push_back(value);
      end
      OP_POP: begin
        if (model_tags.size() == 0) r.status = STAT_EMPTY;
        else r.out_value = model_tags.pop_front();
      end
      OP_REMOVE: begin
        if (value != 32'h0) begin
          if (hit < 0) begin
            r.status = STAT_MISS;
          end else begin
            r.found = 1'b1;
            model_tags.delete(hit);
          end
        end
      end
      default: begin
        if (hit < 0) r.status = STAT_MISS;
        else r.found = 1'b1;
      end
    endcase
    r.count = 5'(model_tags.size());
    return r;
  endfunction

  // Predict on input transactions, check result transactions.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result transaction: status %0d", m_tuser);
          mismatch_count = mismatch_count + 1;
        end else begin
          queue_result_t want;
          want = pending_results.pop_front();
          if (m_tuser != want.status) begin
            $error("status: expected %0d, actual %0d", want.status, m_tuser);
            mismatch_count = mismatch_count + 1;
          end
          if (m_tdata[31:0] != want.out_value) begin
            $error("out_value: expected %h, actual %h", want.out_value, m_tdata[31:0]);
            mismatch_count = mismatch_count + 1;
          end
          if (m_tdata[32] != want.found) begin
            $error("found: expected %0d, actual %0d", want.found, m_tdata[32]);
            mismatch_count = mismatch_count + 1;
          end
          if (m_tdata[37:33] != want.count) begin
            $error("count: expected %0d, actual %0d", want.count, m_tdata[37:33]);
            mismatch_count = mismatch_count + 1;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        queue_result_t predicted;
        predicted = queue_apply(op_t'(s_tuser), s_tdata);
        pending_results.push_back(cur_typed ? cur_res : predicted);
      end
    end
  end

  task automatic send_op(op_t op, logic [31:0] value, logic typed, queue_result_t res);
    while (!calm && $urandom_range(0, 99) < 19) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid  <= 1'b1;
    s_tuser   <= op;
    s_tdata   <= value;
    cur_typed <= typed;
    cur_res   <= res;
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic op_t pick_op(bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 50) return OP_PUSH;
      if (r < 65) return OP_POP;
      if (r < 85) return OP_REMOVE;
      return OP_CONTAINS;
    end
    if (r < 20) return OP_PUSH;
    if (r < 65) return OP_POP;
    if (r < 85) return OP_REMOVE;
    return OP_CONTAINS;
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return tag_pool[$urandom_range(0, 7)];
    if (r < 60 && model_tags.size() > 0)
      return model_tags[$urandom_range(0, model_tags.size() - 1)];
    if (r < 92) return $urandom;
    return (r < 96) ? 32'h0 : 32'hFFFF_FFFF;
  endfunction

  // Receiver: random stalls, one long hold-off, a calm stretch.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && op_index >= HOLD_AT) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= calm || ($urandom_range(0, 99) >= 19);
      end
    end
  end

  initial begin
    bit filling;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = 32'h0;
    s_tuser        = OP_PUSH;
    cur_typed      = 1'b0;
    cur_res        = '0;
    op_index       = 0;
    calm           = 1'b0;
    tag_pool[0]    = 32'h0;
    for (int i = 1; i < 8; i++) tag_pool[i] = $urandom;

    plan_table = '{
      '{OP_POP,      32'h0,         8'd1,  1'b1, '{STAT_EMPTY, 32'h0, 1'b0, 5'd0}},
      '{OP_REMOVE,   32'h5,         8'd1,  1'b1, '{STAT_MISS,  32'h0, 1'b0, 5'd0}},
      '{OP_CONTAINS, 32'h0,         8'd1,  1'b1, '{STAT_MISS,  32'h0, 1'b0, 5'd0}},
      '{OP_REMOVE,   32'h0,         8'd1,  1'b1, '{STAT_DONE,  32'h0, 1'b0, 5'd0}},
      '{OP_PUSH,     32'hFFFF_FFFF, 8'd1,  1'b1, '{STAT_DONE,  32'h0, 1'b0, 5'd1}},
      '{OP_PUSH,     32'h0,         8'd1,  1'b1, '{STAT_DONE,  32'h0, 1'b0, 5'd2}},
      '{OP_CONTAINS, 32'h0,         8'd1,  1'b1, '{STAT_DONE,  32'h0, 1'b1, 5'd2}},
      '{OP_REMOVE,   32'h0,         8'd1,  1'b1, '{STAT_DONE,  32'h0, 1'b0, 5'd2}},
      '{OP_PUSH,     32'hAAAA_AAAA, 8'd1,  1'b0, '0},
      '{OP_PUSH,     32'h5555_5555, 8'd1,  1'b0, '0},
      '{OP_PUSH,     32'hAAAA_AAAA, 8'd1,  1'b0, '0},
      '{OP_REMOVE,   32'hAAAA_AAAA, 8'd1,  1'b0, '0},
      '{OP_POP,      32'h1234_5678, 8'd1,  1'b0, '0},
      '{OP_PUSH,     32'h8000_0001, 8'd13, 1'b0, '0},
      '{OP_PUSH,     32'h1234_5678, 8'd1,  1'b1, '{STAT_FULL,  32'h0, 1'b0, 5'd16}},
      '{OP_CONTAINS, 32'h5555_5555, 8'd1,  1'b1, '{STAT_DONE,  32'h0, 1'b1, 5'd16}},
      '{OP_CONTAINS, 32'h1234_5678, 8'd1,  1'b1, '{STAT_MISS,  32'h0, 1'b0, 5'd16}},
      '{OP_REMOVE,   32'h1234_5678, 8'd1,  1'b1, '{STAT_MISS,  32'h0, 1'b0, 5'd16}},
      '{OP_REMOVE,   32'h8000_0001, 8'd1,  1'b0, '0},
      '{OP_POP,      32'hFFFF_FFFF, 8'd15, 1'b0, '0},
      '{OP_POP,      32'h0,         8'd1,  1'b1, '{STAT_EMPTY, 32'h0, 1'b0, 5'd0}},
      '{OP_CONTAINS, 32'hFFFF_FFFF, 8'd1,  1'b1, '{STAT_MISS,  32'h0, 1'b0, 5'd0}}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan_table[i]) begin
      for (int k = 0; k < plan_table[i].reps; k++) begin
        send_op(plan_table[i].op, plan_table[i].value, plan_table[i].typed,
                plan_table[i].res);
      end
    end

    filling = 1'b1;
    for (int i = 0; i < RANDOM_OPS; i++) begin
      op_index = i;
      calm     = (i >= CALM_FROM && i < CALM_TO);
      if (i % 150 == 0) filling = !filling || (i == 0);
      send_op(pick_op(filling), pick_value(), 1'b0, '0);
    end
    calm = 1'b0;

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/fqrv_pkg.sv
design/fqrv_cell.sv
design/fifo_queue_with_remove_by_value.sv
design/fqrv_checker.sv
tb/sv/tb_top.sv
